// ===== src/acs_pkg.sv =====
`default_nettype none
package acs_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int WCNT_W = 5;
    localparam int ITER_W = 16;
    localparam int DIV_W  = ITER_W + 1;
    localparam int CNT_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITERS  = 1'b1;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_REQUEST = 2'd1,
        OP_FINISH  = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OWN,
        S_SCAN,
        S_PICK,
        S_DIV,
        S_BSIZE,
        S_SWEEP,
        S_MUL,
        S_GRANT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic own_check;
        logic scan_init;
        logic scan_step;
        logic div_start;
        logic div_cfg;
        logic sweep_init;
        logic sweep_step;
        logic mul;
        logic grant_load;
        logic zero_load;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    own_hit;
        logic    scan_last;
        logic    found;
        logic    div_done;
        logic    sweep_last;
        logic    out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== src/acs_div.sv =====
`default_nettype none
module acs_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [acs_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [acs_pkg::WCNT_W-1:0] i_divisor,
    output logic                           o_done,
    output logic      [acs_pkg::DIV_W-1:0]  o_quotient
);
    import acs_pkg::*;

    logic              r_active;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [WCNT_W-1:0] r_rmd;
    logic [WCNT_W-1:0] r_div;
    logic [WCNT_W:0]   shifted;
    logic              q_bit;
    logic [WCNT_W:0]   diff;

    // one quotient bit per cycle
    always_comb begin
        shifted = {r_rmd, r_quo[DIV_W-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rmd <= '0;
            r_div <= i_divisor;
        end else if (r_active) begin
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
            r_rmd <= q_bit ? WCNT_W'(diff) : WCNT_W'(shifted);
        end
    end

    assign o_done     = r_active && (r_cnt == CNT_W'(DIV_W - 1));
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== src/acs_ctrl.sv =====
`default_nettype none
module acs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire acs_pkg::t_dp_sts i_sts,
    output acs_pkg::t_dp_cmd      o_cmd
);
    import acs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_START: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_cfg   = 1'b1;
                        n_state         = S_DIV;
                    end
                    OP_REQUEST: n_state = S_OWN;
                    default:    n_state = S_FIN;
                endcase
            end
            S_OWN: begin
                o_cmd.own_check = 1'b1;
                if (i_sts.own_hit) begin
                    n_state = S_PICK;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.found) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = (i_sts.op == OP_START) ? S_BSIZE : S_MUL;
                end
            end
            S_BSIZE: begin
                o_cmd.sweep_init = 1'b1;
                n_state          = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_GRANT;
            end
            S_GRANT: begin
                if (i_sts.out_free) begin
                    o_cmd.grant_load = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.zero_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/acs_dp.sv =====
`default_nettype none
module acs_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire acs_pkg::t_dp_cmd          i_cmd,
    output acs_pkg::t_dp_sts               o_sts,
    input  wire logic [acs_pkg::WCNT_W-1:0] i_worker_count,
    input  wire logic [acs_pkg::ITER_W-1:0] i_total,
    input  wire acs_pkg::t_opcode          i_op,
    input  wire logic [3:0]                i_worker_id,
    input  wire logic [3:0]                i_finished_owner,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_granted,
    output logic      [3:0]                o_owner_id,
    output logic      [acs_pkg::ITER_W-1:0] o_chunk_low,
    output logic      [acs_pkg::ITER_W-1:0] o_chunk_high
);
    import acs_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int ACC_W = ITER_W + IDX_W + 1;

    logic [ITER_W-1:0]      r_rem_arr [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_busy;

    t_opcode           r_op;
    logic [3:0]        r_me;
    logic [3:0]        r_fin;
    logic [WCNT_W-1:0] r_w;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_owner;
    logic [ITER_W-1:0] r_rem;
    logic [ITER_W-1:0] r_best;
    logic              r_found;
    logic [ITER_W-1:0] r_bs;
    logic [ACC_W-1:0]  r_lo;
    logic [ACC_W-1:0]  r_prod;
    logic              r_out_valid;
    logic              r_granted;
    logic [3:0]        r_owner_id;
    logic [ITER_W-1:0] r_chunk_low;
    logic [ITER_W-1:0] r_chunk_high;

    logic [WCNT_W-1:0] w_eff;
    logic [IDX_W-1:0]  me_addr;
    logic [IDX_W-1:0]  fin_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [ITER_W-1:0] rem_rd;
    logic              busy_rd;
    logic              own_hit;
    logic              scan_take;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [ACC_W-1:0]  sw_sum;
    logic [ACC_W-1:0]  sw_hi;
    logic [ITER_W-1:0] sw_val;
    logic [ITER_W-1:0] g_end;
    logic [ITER_W-1:0] g_size;
    logic [ITER_W-1:0] g_lo;
    logic [ITER_W-1:0] g_hi;
    logic              out_free;

    always_comb begin
        if (i_worker_count == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(i_worker_count) > 32'(MAX_WORKERS)) begin
            w_eff = WCNT_W'(MAX_WORKERS);
        end else begin
            w_eff = i_worker_count;
        end
    end

    assign me_addr  = IDX_W'(r_me);
    assign fin_addr = IDX_W'(r_fin);
    assign rd_addr  = i_cmd.own_check ? me_addr : r_idx;
    assign rem_rd   = r_rem_arr[rd_addr];
    assign busy_rd  = r_busy[rd_addr];

    assign own_hit = (32'(r_me) < 32'(r_w)) && (32'(r_me) < 32'(MAX_WORKERS))
                     && (rem_rd != '0);
    assign scan_take = !busy_rd && (rem_rd > r_best);

    // block split for start
    always_comb begin
        sw_sum = r_lo + ACC_W'(r_bs);
        sw_hi  = (sw_sum > ACC_W'(i_total)) ? ACC_W'(i_total) : sw_sum;
        if ((32'(r_idx) < 32'(r_w)) && (sw_hi > r_lo)) begin
            sw_val = ITER_W'(sw_hi - r_lo);
        end else begin
            sw_val = '0;
        end
    end

    // chunk bounds for grant
    always_comb begin
        g_end  = (r_prod > ACC_W'(i_total)) ? i_total : ITER_W'(r_prod);
        g_size = ITER_W'(div_quo);
        g_lo   = (g_end >= r_rem) ? (g_end - r_rem) : '0;
        g_hi   = g_lo + g_size;
    end

    assign div_dividend = i_cmd.div_cfg
        ? (DIV_W'(i_total) + DIV_W'(r_w) - DIV_W'(1))
        : (DIV_W'(r_rem) + DIV_W'(r_w) - DIV_W'(1));

    acs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_w),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_me  <= i_worker_id;
            r_fin <= i_finished_owner;
            r_w   <= w_eff;
        end
        if (i_cmd.own_check && own_hit) begin
            r_rem   <= rem_rd;
            r_owner <= me_addr;
        end else if (i_cmd.scan_step && scan_take) begin
            r_rem   <= rem_rd;
            r_owner <= r_idx;
        end
        if (i_cmd.scan_init) begin
            r_best <= '0;
        end else if (i_cmd.scan_step && scan_take) begin
            r_best <= rem_rd;
        end
        if (i_cmd.scan_init || i_cmd.sweep_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step || i_cmd.sweep_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.sweep_init) begin
            r_lo <= '0;
        end else if (i_cmd.sweep_step) begin
            r_lo <= sw_sum;
        end
        if (i_cmd.mul) begin
            r_prod <= (ACC_W'(r_owner) + ACC_W'(1)) * ACC_W'(r_bs);
        end
        if (i_cmd.grant_load) begin
            r_granted    <= 1'b1;
            r_owner_id   <= 4'(r_owner);
            r_chunk_low  <= g_lo;
            r_chunk_high <= g_hi;
        end else if (i_cmd.zero_load) begin
            r_granted    <= 1'b0;
            r_owner_id   <= '0;
            r_chunk_low  <= '0;
            r_chunk_high <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_bs        <= '0;
            for (int i = 0; i < MAX_WORKERS; i++) begin
                r_rem_arr[i] <= '0;
            end
        end else begin
            if (i_cmd.sweep_init) begin
                r_bs <= ITER_W'(div_quo);
            end
            if (i_cmd.own_check && own_hit) begin
                r_found <= 1'b1;
            end else if (i_cmd.scan_init) begin
                r_found <= 1'b0;
            end else if (i_cmd.scan_step && scan_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.grant_load || i_cmd.zero_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.sweep_step) begin
                r_rem_arr[r_idx] <= sw_val;
                r_busy[r_idx]    <= 1'b0;
            end else if (i_cmd.grant_load) begin
                r_rem_arr[r_owner] <= r_rem - g_size;
                r_busy[r_owner]    <= 1'b1;
            end else if (i_cmd.zero_load && (r_op == OP_FINISH)
                         && (32'(r_fin) < 32'(MAX_WORKERS))) begin
                r_busy[fin_addr] <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.own_hit    = own_hit;
        o_sts.scan_last  = (32'(r_idx) + 1) == 32'(r_w);
        o_sts.found      = r_found;
        o_sts.div_done   = div_done;
        o_sts.sweep_last = r_idx == IDX_W'(MAX_WORKERS - 1);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_granted;
    assign o_owner_id   = r_owner_id;
    assign o_chunk_low  = r_chunk_low;
    assign o_chunk_high = r_chunk_high;

endmodule
`default_nettype wire

// ===== src/affinity_chunk_scheduler.sv =====
// Affinity loop scheduler: hands out chunks of a loop's iteration space to up to
// MAX_WORKERS workers. A start beat splits the space into one contiguous block per
// worker; a request beat grants ceil(remaining/workers) iterations from the worker's
// own block, or else from the idle block with the most left (lower index on a tie);
// a finish beat clears a block's busy mark. Every input beat gives exactly one result
// beat. Items are handled one at a time: a request checks the worker's own block,
// scans the blocks in index order if that block is empty, then runs the bit-serial
// divider and a multiply; a start runs the divider, then writes one block entry per
// cycle over all MAX_WORKERS entries. The result register lets the next beat be
// accepted while the previous result waits on m_tready.
`default_nettype none
module affinity_chunk_scheduler (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [acs_pkg::ITER_W-1:0]    i_cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // worker_id, finished_owner
    input  wire logic [1:0]                   s_tuser,   // opcode
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [39:0]                  m_tdata,   // owner_id, chunk_low, chunk_high
    output logic                              m_tuser    // granted
);
    import acs_pkg::*;

    logic [WCNT_W-1:0] r_worker_count;
    logic [ITER_W-1:0] r_total;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              granted;
    logic [3:0]        owner_id;
    logic [ITER_W-1:0] chunk_low;
    logic [ITER_W-1:0] chunk_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= WCNT_W'(4);
            r_total        <= ITER_W'(729);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WORKER_COUNT: r_worker_count <= i_cfg_data[WCNT_W-1:0];
                CFG_TOTAL_ITERS:  r_total        <= i_cfg_data;
                default:          r_total        <= r_total;
            endcase
        end
    end

    acs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    acs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_worker_count   (r_worker_count),
        .i_total          (r_total),
        .i_op             (t_opcode'(s_tuser)),
        .i_worker_id      (s_tdata[3:0]),
        .i_finished_owner (s_tdata[7:4]),
        .i_out_ready      (m_tready),
        .o_out_valid      (m_tvalid),
        .o_granted        (granted),
        .o_owner_id       (owner_id),
        .o_chunk_low      (chunk_low),
        .o_chunk_high     (chunk_high)
    );

    assign m_tuser = granted;
    assign m_tdata = {4'b0, chunk_high, chunk_low, owner_id};

endmodule
`default_nettype wire

// ===== tb/sv/affinity_chunk_scheduler_tb.sv =====
`timescale 1ns / 1ps
module affinity_chunk_scheduler_tb;
    import acs_pkg::*;

    localparam int NBLK        = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_BEATS  = 730;

    typedef struct packed {
        logic        granted;
        logic [3:0]  owner;
        logic [15:0] lo;
        logic [15:0] hi;
    } t_grant;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_WORKER_COUNT;
    logic [ITER_W-1:0]    i_cfg_data = '0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata    = '0;
    logic [1:0]           s_tuser    = OP_NOP;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tuser;

    affinity_chunk_scheduler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // scheduler shadow state
    logic [4:0]  sh_workers;
    logic [15:0] sh_total;
    logic [15:0] blk_left [NBLK];
    logic        blk_busy [NBLK];
    logic [15:0] blk_span;

    t_grant grant_q[$];
    int     err_count = 0;
    int     cycles    = 0;
    int     beats_sent = 0;
    bit     idle_en   = 1'b0;
    int     burst_left = 0;
    bit     stall_en  = 1'b0;
    int     rdy_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!stall_en) begin
            m_tready <= 1'b1;
        end else if (rdy_left == 0) begin
            m_tready <= ~m_tready;
            rdy_left = m_tready ? $urandom_range(1, 12) : $urandom_range(1, 16);
        end else begin
            rdy_left--;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[31:0], 0);
            end else begin
                want = grant_q.pop_front();
                if (m_tuser !== want.granted)
                    report_mismatch("granted", 32'(m_tuser), 32'(want.granted));
                if (m_tdata[3:0] !== want.owner)
                    report_mismatch("owner_id", 32'(m_tdata[3:0]), 32'(want.owner));
                if (m_tdata[19:4] !== want.lo)
                    report_mismatch("chunk_low", 32'(m_tdata[19:4]), 32'(want.lo));
                if (m_tdata[35:20] !== want.hi)
                    report_mismatch("chunk_high", 32'(m_tdata[35:20]), 32'(want.hi));
            end
        end
    end

    function automatic int unsigned eff_workers();
        if (sh_workers == 0) return 1;
        if (sh_workers > NBLK) return NBLK;
        return 32'(sh_workers);
    endfunction

    function automatic int unsigned span_end(input int unsigned owner);
        int unsigned e;
        e = (owner + 1) * 32'(blk_span);
        return (e > 32'(sh_total)) ? 32'(sh_total) : e;
    endfunction

    task automatic sched_reset();
        sh_workers = 5'd4;
        sh_total   = 16'd729;
        blk_span   = '0;
        for (int i = 0; i < NBLK; i++) begin
            blk_left[i] = '0;
            blk_busy[i] = 1'b0;
        end
    endtask

    task automatic predict_grant(input t_opcode op, input logic [3:0] wid,
                                 input logic [3:0] fin, output t_grant r);
        int unsigned w, own, best, rem, amt, e, lo;
        bit found;
        r = '0;
        w = eff_workers();
        found = 1'b0;
        own = 0;
        case (op)
            OP_START: begin
                blk_span = 16'((sh_total + w - 1) / w);
                for (int i = 0; i < NBLK; i++) begin
                    blk_busy[i] = 1'b0;
                    blk_left[i] = '0;
                    if (i < w) begin
                        lo = 32'(i) * 32'(blk_span);
                        e = span_end(i);
                        blk_left[i] = (e > lo) ? 16'(e - lo) : 16'd0;
                    end
                end
            end
            OP_FINISH: blk_busy[fin] = 1'b0;
            OP_REQUEST: begin
                if (wid < w && blk_left[wid] > 0) begin
                    own = 32'(wid);
                    found = 1'b1;
                end else begin
                    best = 0;
                    for (int i = 0; i < w; i++) begin
                        if (!blk_busy[i] && blk_left[i] > best) begin
                            best = 32'(blk_left[i]);
                            own = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    rem = 32'(blk_left[own]);
                    amt = (rem + w - 1) / w;
                    e = span_end(own);
                    lo = (e >= rem) ? e - rem : 0;
                    blk_busy[own] = 1'b1;
                    blk_left[own] = 16'(rem - amt);
                    r.granted = 1'b1;
                    r.owner = own[3:0];
                    r.lo = lo[15:0];
                    r.hi = 16'(lo + amt);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input t_opcode op, input logic [3:0] wid, input logic [3:0] fin);
        t_grant r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fin, wid};
        do @(posedge i_clk); while (!s_tready);
        predict_grant(op, wid, fin, r);
        grant_q.push_back(r);
        beats_sent++;
        if (idle_en && burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 2'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    // registers are only touched with the scheduler idle
    task automatic set_cfg(input bit do_wc, input logic [15:0] wc_data,
                           input bit do_tot, input logic [15:0] tot_data);
        drain_results();
        if (do_wc) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_WORKER_COUNT;
            i_cfg_data <= wc_data;
            @(posedge i_clk);
            sh_workers = wc_data[4:0];
        end
        if (do_tot) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_TOTAL_ITERS;
            i_cfg_data <= tot_data;
            @(posedge i_clk);
            sh_total = tot_data;
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_busy();
        int s;
        s = $urandom_range(0, NBLK - 1);
        for (int k = 0; k < NBLK; k++) begin
            if (blk_busy[(s + k) % NBLK]) return 4'((s + k) % NBLK);
        end
        return 4'(s);
    endfunction

    task automatic test_before_start();
        send_beat(OP_REQUEST, 4'd0, 4'd9);
        send_beat(OP_NOP, 4'd15, 4'd15);
        send_beat(OP_FINISH, 4'd3, 4'd0);
    endtask

    task automatic test_default_split();
        send_beat(OP_START, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd3, 4'd0);
        send_beat(OP_REQUEST, 4'd7, 4'd0);
        send_beat(OP_FINISH, 4'd0, 4'd1);
    endtask

    task automatic test_extremes();
        set_cfg(1'b1, 16'd16, 1'b1, 16'hFFFF);
        send_beat(OP_START, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd15, 4'd0);
        send_beat(OP_REQUEST, 4'd0, 4'd15);
        set_cfg(1'b1, 16'd1, 1'b1, 16'd1);
        send_beat(OP_START, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd0, 4'd0);
    endtask

    task automatic test_count_clamp();
        set_cfg(1'b1, 16'd0, 1'b1, 16'd100);
        send_beat(OP_START, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd5, 4'd0);
        set_cfg(1'b1, 16'hFFFF, 1'b1, 16'd17);
        send_beat(OP_START, 4'd0, 4'd0);
        send_beat(OP_REQUEST, 4'd12, 4'd0);
    endtask

    task automatic test_total_shrunk();
        set_cfg(1'b1, 16'd2, 1'b1, 16'd100);
        send_beat(OP_START, 4'd0, 4'd0);
        set_cfg(1'b0, 16'd0, 1'b1, 16'd30);
        send_beat(OP_REQUEST, 4'd1, 4'd0);
        send_beat(OP_REQUEST, 4'd0, 4'd0);
    endtask

    task automatic test_random_phases();
        int n, r, w;
        logic [15:0] wc, tot;
        while (beats_sent < RAND_BEATS) begin
            case ($urandom_range(0, 5))
                0: wc = 16'd1;
                1: wc = 16'd16;
                2: wc = {11'($urandom), 5'($urandom)};
                default: wc = 16'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 6))
                0: tot = 16'd1;
                1: tot = 16'hFFFF;
                2: tot = 16'($urandom);
                default: tot = 16'($urandom_range(1, 300));
            endcase
            set_cfg(1'b1, wc, 1'b1, tot);
            if ($urandom_range(0, 7) == 0)
                set_cfg(1'b0, 16'd0, 1'b1, 16'($urandom_range(1, 400)));
            idle_en  = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            send_beat(OP_START, 4'($urandom), 4'($urandom));
            n = $urandom_range(20, 40);
            for (int k = 0; k < n; k++) begin
                w = eff_workers();
                r = $urandom_range(0, 99);
                if (k == n / 2 && $urandom_range(0, 2) == 0)
                    drain_results();
                if (r < 60) begin
                    send_beat(OP_REQUEST,
                              ($urandom_range(0, 6) != 0) ? 4'($urandom_range(0, w - 1))
                                                           : 4'($urandom),
                              4'($urandom));
                end else if (r < 88) begin
                    send_beat(OP_FINISH, 4'($urandom),
                              ($urandom_range(0, 4) != 0) ? pick_busy() : 4'($urandom));
                end else if (r < 92) begin
                    send_beat(OP_START, 4'($urandom), 4'($urandom));
                end else if (r < 96) begin
                    send_beat(OP_NOP, 4'($urandom), 4'($urandom));
                end else begin
                    send_beat(t_opcode'(2'($urandom)), 4'($urandom), 4'($urandom));
                end
            end
        end
        idle_en  = 1'b0;
        stall_en = 1'b0;
    endtask

    initial begin
        sched_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_start();
        test_default_split();
        test_extremes();
        test_count_clamp();
        test_total_shrunk();
        test_random_phases();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && grant_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
